@@ rtl/sh3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh3_pkg
// Shared types and constants for the 3x3 sharpening convolution core.
// ----------------------------------------------------------------------------
package sh3_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 4096;

	localparam int PIX_W   = 8;
	localparam int IMG_W_W = 11;
	localparam int IMG_H_W = 13;
	localparam int CFG_W   = 13;
	localparam int ROW_W   = 12;
	localparam int CMP_W   = 13;
	localparam int SUM_W   = 12;

	localparam int MIN_DIM    = 3;
	localparam int FIRST_FULL = 2;

	localparam logic [IMG_W_W-1:0] IMG_W_RST = IMG_W_W'(1024);
	localparam logic [IMG_H_W-1:0] IMG_H_RST = IMG_H_W'(1024);

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] upper;
		logic [PIX_W-1:0] lower;
	} line_pair_t;

	typedef struct packed {
		logic produce;
		logic frame_end;
	} pos_ctl_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             clipped;
	} sharp_res_t;

endpackage

@@ rtl/sh3_line_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh3_line_store
// Two line buffers held as one memory of pixel pairs, with a registered read
// and forwarding of a write that lands on the entry being read.
// ----------------------------------------------------------------------------
module sh3_line_store
	import sh3_pkg::*;
#(
	parameter int DEPTH = MAX_WIDTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  line_pair_t    wr_data,
	output line_pair_t    rd_data
);

	line_pair_t mem [DEPTH];
	line_pair_t rd_q;
	line_pair_t fwd_q;
	logic       coll_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q  <= mem[rd_addr];
			fwd_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coll_q <= 1'b0;
		end else if (rd_en) begin
			coll_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = coll_q ? fwd_q : rd_q;

endmodule

@@ rtl/sh3_position.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh3_position
// Column and row counters of the raster scan, with frame start handling and
// the decisions whether an item yields a result and whether it ends a frame.
// ----------------------------------------------------------------------------
module sh3_position
	import sh3_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int CW        = $clog2(MAX_WIDTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               frame_start,
	input  logic [IMG_W_W-1:0] image_width,
	input  logic [IMG_H_W-1:0] image_height,
	output logic [CW-1:0]      col,
	output pos_ctl_t           ctl
);

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [ROW_W-1:0] row_eff;
	logic [CMP_W-1:0] w_ext, h_ext, w_lim, h_lim, col_ext, row_ext;
	logic             col_last, row_last;

	always_comb begin
		col     = frame_start ? '0 : col_q;
		row_eff = frame_start ? '0 : row_q;
		w_ext   = CMP_W'(image_width);
		h_ext   = CMP_W'(image_height);
		if (w_ext < CMP_W'(MIN_DIM)) begin
			w_lim = CMP_W'(MIN_DIM);
		end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
			w_lim = CMP_W'(MAX_WIDTH);
		end else begin
			w_lim = w_ext;
		end
		if (h_ext < CMP_W'(MIN_DIM)) begin
			h_lim = CMP_W'(MIN_DIM);
		end else if (h_ext > CMP_W'(MAX_HEIGHT)) begin
			h_lim = CMP_W'(MAX_HEIGHT);
		end else begin
			h_lim = h_ext;
		end
		col_ext       = CMP_W'(col);
		row_ext       = CMP_W'(row_eff);
		col_last      = (col_ext + CMP_W'(1)) >= w_lim;
		row_last      = (row_ext + CMP_W'(1)) >= h_lim;
		ctl.produce   = (col_ext >= CMP_W'(FIRST_FULL)) && (row_ext >= CMP_W'(FIRST_FULL));
		ctl.frame_end = col_last && row_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_eff + ROW_W'(1);
			end else begin
				col_q <= col + CW'(1);
				row_q <= row_eff;
			end
		end
	end

endmodule

@@ rtl/sh3_window_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh3_window_alu
// Window registers of the two previous columns and the five-tap sharpening
// sum with saturation to the pixel range.
// ----------------------------------------------------------------------------
module sh3_window_alu
	import sh3_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [PIX_W-1:0] pix,
	input  logic [PIX_W-1:0] top,
	input  logic [PIX_W-1:0] mid,
	output sharp_res_t       res
);

	logic [PIX_W-1:0]        left_mid_q;
	logic [PIX_W-1:0]        col_top_q, col_mid_q, col_bot_q;
	logic signed [SUM_W-1:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_mid_q <= '0;
			col_top_q  <= '0;
			col_mid_q  <= '0;
			col_bot_q  <= '0;
		end else if (step) begin
			left_mid_q <= col_mid_q;
			col_top_q  <= top;
			col_mid_q  <= mid;
			col_bot_q  <= pix;
		end
	end

	always_comb begin
		sum = $signed(SUM_W'({col_mid_q, 2'b00}) + SUM_W'(col_mid_q)
			- SUM_W'(col_top_q) - SUM_W'(col_bot_q)
			- SUM_W'(left_mid_q) - SUM_W'(mid));
		if (sum < 0) begin
			res.pixel   = '0;
			res.clipped = 1'b1;
		end else if (sum > SUM_W'(255)) begin
			res.pixel   = '1;
			res.clipped = 1'b1;
		end else begin
			res.pixel   = sum[PIX_W-1:0];
			res.clipped = 1'b0;
		end
	end

endmodule

@@ rtl/sharpen_3x3_convolution_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharpen_3x3_convolution_core
// 3x3 Laplacian sharpening of a raster-order 8-bit grayscale pixel stream.
//
//   Channel   Handshake                    Payload
//   pixel     pixel_valid / pixel_ready    pixel_in, frame_start
//   result    result_valid / result_ready  pixel_out, clipped, frame_end
//   config    cfg_write                    cfg_index, cfg_data
//
// One pixel item is taken per cycle while the result side is not stalled.
// A result is registered after its pixel is accepted: the accepting edge loads
// the input register and the line store read, a later advancing edge loads
// the window and the output register from the sum. Reset clears counters,
// window and valid flags; line stores are not cleared. A stalled result
// register holds the whole pipeline.
// ----------------------------------------------------------------------------
module sharpen_3x3_convolution_core
	import sh3_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pixel_valid,
	output logic               pixel_ready,
	input  logic [PIX_W-1:0]   pixel_in,
	input  logic               frame_start,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [PIX_W-1:0]   pixel_out,
	output logic               clipped,
	output logic               frame_end,
	input  logic               cfg_write,
	input  logic [0:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [IMG_W_W-1:0] image_width_q;
	logic [IMG_H_W-1:0] image_height_q;

	logic             adv, in_fire, wr_en;
	logic [CW-1:0]    col;
	pos_ctl_t         ctl;
	line_pair_t       rd_data, wr_data;
	sharp_res_t       res;

	logic             valid_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [CW-1:0]    col_s1;
	pos_ctl_t         ctl_s1;
	logic             result_valid_q;
	sharp_res_t       res_q;
	logic             frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMG_W_RST;
			image_height_q <= IMG_H_RST;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[IMG_H_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv         = !result_valid_q || result_ready;
	assign pixel_ready = adv;
	assign in_fire     = pixel_valid && adv;
	assign wr_en       = adv && valid_s1;
	assign wr_data     = '{upper: rd_data.lower, lower: pix_s1};

	sh3_position #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_position (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (in_fire),
		.frame_start  (frame_start),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.col          (col),
		.ctl          (ctl)
	);

	sh3_line_store #(
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (adv),
		.rd_addr (col),
		.wr_en   (wr_en),
		.wr_addr (col_s1),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	sh3_window_alu u_window_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (wr_en),
		.pix    (pix_s1),
		.top    (rd_data.upper),
		.mid    (rd_data.lower),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1       <= in_fire;
			result_valid_q <= valid_s1 && ctl_s1.produce;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1      <= pixel_in;
			col_s1      <= col;
			ctl_s1      <= ctl;
			res_q       <= res;
			frame_end_q <= ctl_s1.frame_end;
		end
	end

	assign result_valid = result_valid_q;
	assign pixel_out    = res_q.pixel;
	assign clipped      = res_q.clipped;
	assign frame_end    = frame_end_q;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 sharpening core. Pixel items come from a
// queue and are driven on falling edges. Each accepted pixel is run through
// a local line-store and window predictor. Each accepted result is compared
// with the oldest predicted one. Frame geometry is changed only while the core
// is idle: at full-frame boundaries, inside frames, and at the largest sizes.
// ----------------------------------------------------------------------------
module testbench;
	import sh3_pkg::*;

	localparam int CENTER_WEIGHT  = 5;
	localparam int RESET_CYCLES   = 6;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;
	localparam int RANDOM_ITEMS   = 1300;
	localparam int TALL_ROWS      = 20;

	localparam logic [PIX_W-1:0] DIRECTED_PIX [24] = '{
		255,   0, 255,
		  0, 255,   0,
		255,   0, 255,
		255, 255, 255,
		  0,   0,   0,
		  0,  60,   0,
		 55,  45,  55,
		  0,  55,   0
	};

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             fs;
	} pixel_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             clip;
		logic             fend;
	} sharp_out_t;

	typedef enum int {
		TEX_NOISE,
		TEX_FLAT,
		TEX_RAIL
	} texture_e;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               pixel_valid = 1'b0;
	logic               pixel_ready;
	logic [PIX_W-1:0]   pixel_in = '0;
	logic               frame_start = 1'b0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [PIX_W-1:0]   pixel_out;
	logic               clipped;
	logic               frame_end;
	logic               cfg_write = 1'b0;
	logic [0:0]         cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;

	pixel_item_t        pixel_q[$];
	sharp_out_t         sharpened_q[$];

	logic [IMG_W_W-1:0] width_reg = IMG_W_RST;
	logic [IMG_H_W-1:0] height_reg = IMG_H_RST;
	logic [PIX_W-1:0]   row_m2_store [MAX_WIDTH_DEF];
	logic [PIX_W-1:0]   row_m1_store [MAX_WIDTH_DEF];
	logic [PIX_W-1:0]   win_older [3] = '{'0, '0, '0};
	logic [PIX_W-1:0]   win_newer [3] = '{'0, '0, '0};
	int                 col_pos = 0;
	int                 row_pos = 0;

	int                 src_idle_pct = 6;
	int                 snk_stall_pct = 71;
	int                 accepted_count = 0;
	bit                 px_taken = 1'b0;
	int                 quiet_cycles = 0;
	int                 error_count = 0;

	sharpen_3x3_convolution_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel_in     (pixel_in),
		.frame_start  (frame_start),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.pixel_out    (pixel_out),
		.clipped      (clipped),
		.frame_end    (frame_end),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int clamp_dim(int value, int hi);
		if (value < MIN_DIM)
			return MIN_DIM;
		if (value > hi)
			return hi;
		return value;
	endfunction

	task automatic sharpen_predict(input logic [PIX_W-1:0] pix, input logic fs);
		int w;
		int h;
		int idx;
		int acc;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		sharp_out_t res;
		w = clamp_dim(int'(width_reg), MAX_WIDTH_DEF);
		h = clamp_dim(int'(height_reg), MAX_HEIGHT);
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		idx = (col_pos < MAX_WIDTH_DEF) ? col_pos : MAX_WIDTH_DEF - 1;
		top = row_m2_store[idx];
		mid = row_m1_store[idx];
		row_m2_store[idx] = mid;
		row_m1_store[idx] = pix;
		if (col_pos >= FIRST_FULL && row_pos >= FIRST_FULL) begin
			acc = CENTER_WEIGHT * int'(win_newer[1]) - int'(win_newer[0])
				- int'(win_newer[2]) - int'(win_older[1]) - int'(mid);
			res.clip = (acc < 0) || (acc > 255);
			res.pix = (acc < 0) ? '0 : (acc > 255) ? '1 : acc[PIX_W-1:0];
			res.fend = (row_pos >= h - 1) && (col_pos >= w - 1);
			sharpened_q.push_back(res);
		end
		win_older = win_newer;
		win_newer = '{top, mid, pix};
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			width_reg = value[IMG_W_W-1:0];
		else
			height_reg = value[IMG_H_W-1:0];
	endtask

	task automatic wait_idle();
		while (pixel_q.size() != 0 || pixel_valid || sharpened_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_pacing(input int done);
		if (done < RANDOM_ITEMS / 3) begin
			src_idle_pct = 6;
			snk_stall_pct = 71;
		end else if (done < 2 * RANDOM_ITEMS / 3) begin
			src_idle_pct = 71;
			snk_stall_pct = 6;
		end else begin
			src_idle_pct = 0;
			snk_stall_pct = 0;
		end
	endtask

	task automatic queue_frame(input int n, input logic fs_first);
		texture_e tex;
		int base;
		int v;
		pixel_item_t it;
		tex = texture_e'($urandom_range(0, 2));
		base = $urandom_range(0, 255);
		for (int i = 0; i < n; i++) begin
			case (tex)
			TEX_NOISE: v = $urandom_range(0, 255);
			TEX_FLAT: begin
				v = base + int'($urandom_range(0, 16)) - 8;
				if (v < 0)
					v = 0;
				else if (v > 255)
					v = 255;
			end
			default: v = $urandom_range(0, 1) ? 255 : 0;
			endcase
			it.pix = v[PIX_W-1:0];
			it.fs = (i == 0) && fs_first;
			pixel_q.push_back(it);
		end
	endtask

	always @(negedge clk) begin
		pixel_item_t it;
		if (!pixel_valid || px_taken) begin
			if (pixel_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				it = pixel_q.pop_front();
				pixel_valid <= 1'b1;
				pixel_in <= it.pix;
				frame_start <= it.fs;
			end else begin
				pixel_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		sharp_out_t want;
		px_taken = pixel_valid && pixel_ready;
		if (px_taken) begin
			sharpen_predict(pixel_in, frame_start);
			accepted_count++;
			set_pacing(accepted_count);
		end
		if (result_valid && result_ready) begin
			if (sharpened_q.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("%0t: result with none expected: pixel_out=%0d clipped=%0b frame_end=%0b",
						$time, pixel_out, clipped, frame_end);
			end else begin
				want = sharpened_q.pop_front();
				if (want.pix !== pixel_out || want.clip !== clipped || want.fend !== frame_end) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("%0t: expected pixel_out=%0d clipped=%0b frame_end=%0b, got %0d %0b %0b",
							$time, want.pix, want.clip, want.fend, pixel_out, clipped, frame_end);
				end
			end
		end
		if (px_taken || (result_valid && result_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		pixel_item_t it;
		logic [CFG_W-1:0] cfg;
		logic fs_first;
		int old_w;
		int w;
		int h;
		int nframes;
		int n;
		int random_items;
		bit wide_done;
		bit tall_done;
		random_items = 0;
		wide_done = 1'b0;
		tall_done = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Two back-to-back 3x4 frames: both clip directions, then both exact limits.
		write_reg(REG_IMAGE_WIDTH, CFG_W'(MIN_DIM));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(4));
		@(posedge clk);
		foreach (DIRECTED_PIX[i]) begin
			it.pix = DIRECTED_PIX[i];
			it.fs = (i == 0);
			pixel_q.push_back(it);
		end
		wait_idle();

		while (random_items < RANDOM_ITEMS) begin
			if (!wide_done) begin
				wide_done = 1'b1;
				write_reg(REG_IMAGE_WIDTH, '1);
				write_reg(REG_IMAGE_HEIGHT, CFG_W'(MIN_DIM));
				@(posedge clk);
				// One full row at the clamped width and the start of the next.
				queue_frame(MAX_WIDTH_DEF + MIN_DIM, 1'b1);
				random_items += MAX_WIDTH_DEF + MIN_DIM;
				wait_idle();
				write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(3, 12)));
			end else if (!tall_done && random_items >= 1000) begin
				tall_done = 1'b1;
				write_reg(REG_IMAGE_WIDTH, '0);
				write_reg(REG_IMAGE_HEIGHT, '1);
				@(posedge clk);
				queue_frame(MIN_DIM * TALL_ROWS, 1'b1);
				random_items += MIN_DIM * TALL_ROWS;
				wait_idle();
				write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(3, 8)));
			end else begin
				old_w = clamp_dim(int'(width_reg), MAX_WIDTH_DEF);
				if ($urandom_range(0, 1)) begin
					case ($urandom_range(0, 9))
					0: cfg = CFG_W'($urandom_range(0, 2));
					1: cfg = CFG_W'($urandom_range(13, 48));
					default: cfg = CFG_W'($urandom_range(3, 12));
					endcase
					if ($urandom_range(0, 3) == 0)
						cfg[CFG_W-1:IMG_W_W] = $urandom_range(1, 3);
					write_reg(REG_IMAGE_WIDTH, cfg);
				end
				if ($urandom_range(0, 1)) begin
					case ($urandom_range(0, 9))
					0: cfg = CFG_W'($urandom_range(0, 2));
					1: cfg = CFG_W'($urandom_range(9, 20));
					default: cfg = CFG_W'($urandom_range(3, 8));
					endcase
					write_reg(REG_IMAGE_HEIGHT, cfg);
				end
				w = clamp_dim(int'(width_reg), MAX_WIDTH_DEF);
				h = clamp_dim(int'(height_reg), MAX_HEIGHT);
				// A wider row would read line store columns not yet written in this frame.
				fs_first = (w > old_w) || ($urandom_range(0, 3) != 0);
				@(posedge clk);
				nframes = $urandom_range(1, 3);
				for (int f = 0; f < nframes; f++) begin
					n = w * h;
					if ($urandom_range(0, 4) == 0)
						n = $urandom_range(1, n - 1);
					if (n > RANDOM_ITEMS - random_items)
						n = RANDOM_ITEMS - random_items;
					queue_frame(n, fs_first);
					random_items += n;
					fs_first = ($urandom_range(0, 3) != 0);
				end
				wait_idle();
			end
		end

		wait_idle();
		if (error_count == 0 && sharpened_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
